// ===== design/modbus_rtu_sensor_responder_core_defines.svh =====
// Assertion macros for the Modbus RTU sensor responder.
// Used by design files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef MODBUS_RTU_SENSOR_RESPONDER_CORE_DEFINES_SVH
`define MODBUS_RTU_SENSOR_RESPONDER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRSR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mrsr_pkg.sv =====
// Shared types, constants and the CRC step for the Modbus RTU sensor responder.
// No dependencies; used by the responder core.
package mrsr_pkg;

	// Frame geometry.
	localparam int FRAME_LEN = 8;
	localparam int POS_W     = 3;
	localparam int BYTE_W    = 8;

	localparam logic [POS_W-1:0] CRC_LO_POS = 3'd6;
	localparam logic [POS_W-1:0] CRC_HI_POS = 3'd7;
	localparam logic [POS_W-1:0] LAST_POS   = 3'd7;

	// Modbus CRC-16 and protocol codes.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]  FUNC_ECHO = 8'h00;
	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam logic [7:0]  ERR_FLAG  = 8'h80;

	localparam logic [15:0] ERR_BAD_FUNCTION = 16'h0001;
	localparam logic [15:0] ERR_BAD_REGISTER = 16'h0002;

	localparam logic [15:0] REG_ACCEL_X = 16'd1;
	localparam logic [15:0] REG_ACCEL_Y = 16'd2;
	localparam logic [15:0] REG_ACCEL_Z = 16'd3;

	localparam logic [7:0]  NODE_ID_RESET = 8'd6;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_RX    = 4'b0001,
		ST_READ  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_SEND  = 4'b1000
	} state_t;

	// One byte of the reflected CRC-16, bit by bit.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/modbus_rtu_sensor_responder_core.sv =====
// Top level of the Modbus RTU sensor responder: frame store, sequencer and reply builder.
// Depends on mrsr_pkg, mrsr_ram and the assertion macro header.
//
// The block takes request bytes one per transaction and cuts them into fixed 8-byte
// frames counted from reset; it never realigns. Each byte is written to the frame
// store. After the eighth byte, input is held off while the sequencer reads the
// frame back through the store's single, registered read port, one byte per cycle,
// and checks CRC and address. A frame that fails is dropped with no reply; one that
// passes yields an 8-byte reply, one transaction per cycle while the sink is ready,
// with the reply CRC built as the bytes go out. The acceleration samples are taken
// from the transaction that carries the eighth byte.
`include "modbus_rtu_sensor_responder_core_defines.svh"

module modbus_rtu_sensor_responder_core
	import mrsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: node_id.
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// Request stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // rx_byte[7:0], accel_x[23:8], accel_y[39:24], accel_z[55:40]
	// Reply stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // tx_byte[7:0]
	output logic        m_axis_tlast
);

	// Input fields.
	logic [7:0]         rx_byte;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	assign rx_byte = s_axis_tdata[7:0];
	assign accel_x = s_axis_tdata[23:8];
	assign accel_y = s_axis_tdata[39:24];
	assign accel_z = s_axis_tdata[55:40];

	// Control state.
	state_t            state_q;
	logic [POS_W-1:0]  pos_q;
	logic [7:0]        node_id_q;
	logic [POS_W:0]    rd_cnt_q;
	logic              rd_vld_s1;
	logic [POS_W-1:0]  rd_idx_s1;
	logic [POS_W-1:0]  tx_idx_q;

	// Payload state.
	logic [7:0]         frm_q [FRAME_LEN];
	logic [7:0]         rep_q [FRAME_LEN-2];
	logic [15:0]        crc_q;
	logic signed [15:0] acc_x_q;
	logic signed [15:0] acc_y_q;
	logic signed [15:0] acc_z_q;

	// Handshakes.
	logic in_acc;
	logic out_acc;

	assign s_axis_tready = (state_q == ST_RX);
	assign m_axis_tvalid = (state_q == ST_SEND);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_acc       = m_axis_tvalid & m_axis_tready;

	// Frame store.
	logic             ram_re;
	logic [POS_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	assign ram_re    = (state_q == ST_READ) & ~rd_cnt_q[POS_W];
	assign ram_raddr = rd_cnt_q[POS_W-1:0];

	mrsr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FRAME_LEN)
	) u_frame_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr (pos_q),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Frame check and reply body.
	logic [7:0]  func;
	logic [15:0] reg_num;
	logic [15:0] crc_got;
	logic        frame_ok;
	logic [15:0] err_code;
	logic [7:0]  rep_d [FRAME_LEN-2];

	assign func     = frm_q[1];
	assign reg_num  = {frm_q[2], frm_q[3]};
	assign crc_got  = {frm_q[7], frm_q[6]};
	assign frame_ok = (crc_q == crc_got) && (frm_q[0] == node_id_q);
	assign err_code = (func == FUNC_READ) ? ERR_BAD_REGISTER : ERR_BAD_FUNCTION;

	always_comb begin
		for (int i = 0; i < FRAME_LEN - 2; i++) begin
			rep_d[i] = frm_q[i];
		end
		if (func == FUNC_ECHO) begin
			// Echo the request body unchanged.
		end else if (func == FUNC_READ && reg_num == REG_ACCEL_X) begin
			rep_d[4] = acc_x_q[15:8];
			rep_d[5] = acc_x_q[7:0];
		end else if (func == FUNC_READ && reg_num == REG_ACCEL_Y) begin
			rep_d[4] = acc_y_q[15:8];
			rep_d[5] = acc_y_q[7:0];
		end else if (func == FUNC_READ && reg_num == REG_ACCEL_Z) begin
			rep_d[4] = acc_z_q[15:8];
			rep_d[5] = acc_z_q[7:0];
		end else begin
			rep_d[1] = func | ERR_FLAG;
			rep_d[2] = err_code[15:8];
			rep_d[3] = err_code[7:0];
			rep_d[4] = 8'h00;
			rep_d[5] = 8'h00;
		end
	end

	// Reply byte selection: body bytes, then the CRC low byte first.
	always_comb begin
		case (tx_idx_q)
			CRC_LO_POS: m_axis_tdata = crc_q[7:0];
			CRC_HI_POS: m_axis_tdata = crc_q[15:8];
			default:    m_axis_tdata = rep_q[tx_idx_q];
		endcase
	end

	assign m_axis_tlast = (tx_idx_q == LAST_POS);

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RX;
			pos_q     <= '0;
			node_id_q <= NODE_ID_RESET;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			tx_idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				node_id_q <= cfg_wdata;
			end
			rd_vld_s1 <= ram_re;
			rd_idx_s1 <= ram_raddr;
			case (state_q)
				ST_RX: begin
					if (in_acc) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == LAST_POS) begin
							state_q  <= ST_READ;
							rd_cnt_q <= '0;
						end
					end
				end
				ST_READ: begin
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (rd_vld_s1 && rd_idx_s1 == LAST_POS) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					tx_idx_q <= '0;
					state_q  <= frame_ok ? ST_SEND : ST_RX;
				end
				ST_SEND: begin
					if (out_acc) begin
						tx_idx_q <= tx_idx_q + 1'b1;
						if (tx_idx_q == LAST_POS) begin
							state_q <= ST_RX;
						end
					end
				end
				default: begin
					state_q <= ST_RX;
				end
			endcase
		end
	end

	// Frame capture, CRC accumulation and reply registers.
	always_ff @(posedge clk) begin
		if (in_acc && pos_q == LAST_POS) begin
			acc_x_q <= accel_x;
			acc_y_q <= accel_y;
			acc_z_q <= accel_z;
			crc_q   <= CRC_INIT;
		end
		if (rd_vld_s1) begin
			frm_q[rd_idx_s1] <= ram_rdata;
			if (rd_idx_s1 < CRC_LO_POS) begin
				crc_q <= crc16_byte(crc_q, ram_rdata);
			end
		end
		if (state_q == ST_CHECK) begin
			crc_q <= CRC_INIT;
			for (int i = 0; i < FRAME_LEN - 2; i++) begin
				rep_q[i] <= rep_d[i];
			end
		end
		if (out_acc && tx_idx_q < CRC_LO_POS) begin
			crc_q <= crc16_byte(crc_q, m_axis_tdata);
		end
	end

	// Checks on the sequencer.
	`MRSR_ASSERT_SAME(a_one_side, s_axis_tready, !m_axis_tvalid, "input and reply both open")
	`MRSR_ASSERT_NEXT(a_frame_close, in_acc && pos_q == LAST_POS, state_q == ST_READ,
		"eighth byte did not start read-back")
	`MRSR_ASSERT_NEXT(a_reply_end, out_acc && m_axis_tlast, s_axis_tready && pos_q == '0,
		"last reply byte did not return to receive")
	`MRSR_ASSERT_SAME(a_read_phase, rd_vld_s1, state_q == ST_READ, "read data outside read-back")

endmodule

// ===== design/mrsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mrsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
